@@ sv/i2cm_pkg.sv @@
package i2cm_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam logic [3:0] BITS_PER_BYTE = 4'(BitsPerByte);
  localparam logic [7:0] PHASE_TICKS_RST = 8'd1;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd2555;

  // Configuration register indexes
  localparam logic CFG_PHASE_TICKS = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    CMD_IDLE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ_ACK  = 3'd4,
    CMD_READ_NACK = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       timed_out;
  } res_item_t;

  // Classified tick as it travels from front to sequencer
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
  } tick_t;

  // Handshake between front queue and sequencer
  typedef struct packed {
    logic valid;
    tick_t tick;
  } tick_ch_t;

endpackage

@@ sv/i2cm_front.sv @@
module i2cm_front import i2cm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  output tick_ch_t tick_o,
  input  logic     tick_take_i
);

  tick_t      mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  tick_t      cls;
  logic       wr, rd;

  // Map unknown modes onto no command
  always_comb begin
    cls.tx_byte = in_item_i.tx_byte;
    cls.sda_in  = in_item_i.sda_in;
    if (in_item_i.mode >= 3'(CMD_START) && in_item_i.mode <= 3'(CMD_READ_NACK)) begin
      cls.cmd = cmd_e'(in_item_i.mode);
    end else begin
      cls.cmd = CMD_IDLE;
    end
  end

  assign full = (cnt_q == 2'd2);
  assign wr = push && !full;
  assign rd = tick_take_i && (cnt_q != 2'd0);

  assign tick_o.valid = (cnt_q != 2'd0);
  assign tick_o.tick  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wr ? ~wptr_q : wptr_q;
    rptr_d = rd ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= cls;
    end
  end

endmodule

@@ sv/i2cm_seq.sv @@
module i2cm_seq import i2cm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  tick_ch_t    tick_i,
  output logic        tick_take_o,
  input  logic        res_full_i,
  output logic        res_push_o,
  output res_item_t   res_o
);

  logic [7:0]  phase_ticks_q;
  logic [15:0] ack_timeout_q;

  cmd_e        cmd_q, cmd_d;
  logic [2:0]  step_q, step_d;
  logic [3:0]  bc_q, bc_d;
  logic [7:0]  sh_q, sh_d;
  logic [7:0]  pt_q, pt_d;
  logic [15:0] wt_q, wt_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic [7:0]  rx_q, rx_d;
  logic [1:0]  st_q, st_d;
  logic        fin;
  logic [7:0]  hold;

  assign tick_take_o = tick_i.valid && !res_full_i;
  assign res_push_o  = tick_take_o;
  assign hold = (phase_ticks_q == 8'd0) ? 8'd0 : phase_ticks_q - 8'd1;

  always_comb begin
    cmd_d  = cmd_q;
    step_d = step_q;
    bc_d   = bc_q;
    sh_d   = sh_q;
    pt_d   = pt_q;
    wt_d   = wt_q;
    scl_d  = scl_q;
    sda_d  = sda_q;
    rx_d   = rx_q;
    st_d   = st_q;
    fin    = 1'b0;

    // Take a new command only while idle
    if (cmd_q == CMD_IDLE && tick_i.tick.cmd != CMD_IDLE) begin
      cmd_d  = tick_i.tick.cmd;
      step_d = 3'd0;
      bc_d   = 4'd0;
      pt_d   = 8'd0;
      sh_d   = (tick_i.tick.cmd == CMD_WRITE) ? tick_i.tick.tx_byte : 8'd0;
      if (tick_i.tick.cmd == CMD_WRITE) st_d = 2'b00;
    end

    if (cmd_d != CMD_IDLE) begin
      if (pt_d != 8'd0) begin
        pt_d = pt_d - 8'd1;
      end else begin
        unique case (cmd_d)
          CMD_START: begin
            if (step_d == 3'd0) begin
              scl_d = 1'b1; sda_d = 1'b1; step_d = 3'd1; pt_d = hold;
            end else if (step_d == 3'd1) begin
              sda_d = 1'b0; step_d = 3'd2; pt_d = hold;
            end else begin
              scl_d = 1'b0; fin = 1'b1;
            end
          end
          CMD_STOP: begin
            if (step_d == 3'd0) begin
              scl_d = 1'b0; sda_d = 1'b0; step_d = 3'd1; pt_d = hold;
            end else if (step_d == 3'd1) begin
              scl_d = 1'b1; step_d = 3'd2; pt_d = hold;
            end else begin
              sda_d = 1'b1; fin = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (step_d == 3'd0) begin
              scl_d = 1'b0; step_d = 3'd1; pt_d = hold;
            end else if (step_d == 3'd1) begin
              sda_d  = sh_d[7];
              sh_d   = {sh_d[6:0], 1'b0};
              step_d = 3'd2; pt_d = hold;
            end else if (step_d == 3'd2) begin
              scl_d  = 1'b1;
              bc_d   = bc_d + 4'd1;
              step_d = (bc_d < BITS_PER_BYTE) ? 3'd0 : 3'd3;
              pt_d   = hold;
            end else if (step_d == 3'd3) begin
              scl_d = 1'b0; sda_d = 1'b1; step_d = 3'd4; pt_d = hold;
            end else if (step_d == 3'd4) begin
              scl_d = 1'b1; wt_d = ack_timeout_q; step_d = 3'd5; pt_d = hold;
            end else if (!tick_i.tick.sda_in) begin
              scl_d = 1'b0; st_d = 2'b01; fin = 1'b1;
            end else begin
              wt_d = wt_d - 16'd1;
              // Out of polls: flag and fall into a stop sequence
              if (wt_d == 16'd0) begin
                st_d   = 2'b10;
                cmd_d  = CMD_STOP;
                step_d = 3'd0;
                pt_d   = 8'd0;
              end
            end
          end
          default: begin
            if (step_d == 3'd0) begin
              scl_d = 1'b0; sda_d = 1'b1; step_d = 3'd1; pt_d = hold;
            end else if (step_d == 3'd1) begin
              scl_d = 1'b1; step_d = 3'd2; pt_d = hold;
            end else if (step_d == 3'd2) begin
              sh_d  = {sh_d[6:0], tick_i.tick.sda_in};
              scl_d = 1'b0;
              bc_d  = bc_d + 4'd1;
              if (bc_d < BITS_PER_BYTE) begin
                step_d = 3'd1;
              end else begin
                rx_d   = sh_d;
                sda_d  = (cmd_d == CMD_READ_NACK);
                step_d = 3'd3;
              end
              pt_d = hold;
            end else if (step_d == 3'd3) begin
              scl_d = 1'b1; step_d = 3'd4; pt_d = hold;
            end else begin
              scl_d = 1'b0; fin = 1'b1;
            end
          end
        endcase
      end
    end

    if (fin) begin
      cmd_d  = CMD_IDLE;
      step_d = 3'd0;
    end
  end

  always_comb begin
    res_o.scl_level = scl_d;
    res_o.sda_level = sda_d;
    res_o.busy_res  = (cmd_d != CMD_IDLE);
    res_o.done_res  = fin;
    res_o.rx_byte   = rx_d;
    res_o.ack_seen  = st_d[0];
    res_o.timed_out = st_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RST;
      ack_timeout_q <= ACK_TIMEOUT_RST;
      cmd_q  <= CMD_IDLE;
      step_q <= 3'd0;
      bc_q   <= 4'd0;
      sh_q   <= 8'd0;
      pt_q   <= 8'd0;
      wt_q   <= 16'd0;
      scl_q  <= 1'b1;
      sda_q  <= 1'b1;
      rx_q   <= 8'd0;
      st_q   <= 2'b00;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PHASE_TICKS) phase_ticks_q <= cfg_data_i[7:0];
        if (cfg_idx_i == CFG_ACK_TIMEOUT) ack_timeout_q <= cfg_data_i;
      end
      if (tick_take_o) begin
        cmd_q  <= cmd_d;
        step_q <= step_d;
        bc_q   <= bc_d;
        sh_q   <= sh_d;
        pt_q   <= pt_d;
        wt_q   <= wt_d;
        scl_q  <= scl_d;
        sda_q  <= sda_d;
        rx_q   <= rx_d;
        st_q   <= st_d;
      end
    end
  end

endmodule

@@ sv/i2cm_res_q.sv @@
module i2cm_res_q import i2cm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  res_item_t wdata_i,
  output logic      full_o,
  output logic      empty,
  input  logic      pop,
  output res_item_t res_o
);

  res_item_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       wr, rd;

  assign full_o = (cnt_q == 2'd2);
  assign empty  = (cnt_q == 2'd0);
  assign wr     = wr_i && !full_o;
  assign rd     = pop && !empty;
  assign res_o  = mem_q[rptr_q];
  assign cnt_d  = cnt_q + 2'(wr) - 2'(rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ sv/i2c_master_bit_engine.sv @@
// Channel   Handshake              Payload      Transaction when
// tick in   push / full            in_item_i    push high, full low
// result    empty / pop            res_o        pop high, empty low
// config    cfg_we_i, cfg_idx_i    cfg_data_i   cfg_we_i high
//
// One tick in, one result out; a tick can follow another every clock while neither queue is full.
// A result reaches res_o only after the front queue registers its tick and
// the result queue registers the sequencer's result; either queue may hold it.
// The rate is set by the sequencer's single state update per clock.
// Reset releases both lines and leaves the sequencer idle.
// Either side may stall: each two-entry queue holds ticks or results.
module i2c_master_bit_engine import i2cm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output res_item_t   res_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  tick_ch_t  tick;
  logic      tick_take;
  logic      res_full;
  logic      res_push;
  res_item_t res_new;

  // Classify modes and queue ticks
  i2cm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .tick_o      (tick),
    .tick_take_i (tick_take)
  );

  // Advance the line sequencer one tick per transaction
  i2cm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .tick_i      (tick),
    .tick_take_o (tick_take),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  // Hold results until taken
  i2cm_res_q u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_push),
    .wdata_i (res_new),
    .full_o  (res_full),
    .empty   (empty),
    .pop     (pop),
    .res_o   (res_o)
  );

endmodule
